/* rtl/pdc_pkg.sv */
// Package for the pump duty-cycle controller.
// Holds widths, register indexes, reset values and shared types.
// No dependencies.
package pdc_pkg;

  localparam int NOW_W   = 32;
  localparam int TOD_W   = 27;
  localparam int LIGHT_W = 10;
  localparam int MIN_W   = 11;
  localparam int THR_W   = 7;
  localparam int SPAN_W  = 27;
  localparam int PCT_W   = 17;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 27;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  localparam logic [15:0]        MS_PER_MIN  = 16'd60000;
  localparam logic [LIGHT_W-1:0] LIGHT_FULL  = 10'd1023;
  localparam logic [6:0]         PCT_SCALE   = 7'd100;

  typedef enum logic [1:0] {
    RUN_OFF      = 2'd0,
    RUN_NORMAL   = 2'd1,
    RUN_WINDOW   = 2'd2,
    RUN_DAYLIGHT = 2'd3
  } run_mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_RUN_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_MINUTES   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_MINUTES  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_START = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_STOP  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_THR    = 3'd5;

  localparam logic [MIN_W-1:0] RST_ON_MINUTES   = 11'd15;
  localparam logic [MIN_W-1:0] RST_OFF_MINUTES  = 11'd15;
  localparam logic [TOD_W-1:0] RST_WINDOW_START = 27'd28800000;
  localparam logic [TOD_W-1:0] RST_WINDOW_STOP  = 27'd64800000;
  localparam logic [THR_W-1:0] RST_LIGHT_THR    = 7'd50;

  // Settings as seen by the decision logic; spans are in ms,
  // the threshold is pre-scaled by 1023.
  typedef struct packed {
    run_mode_t         run_mode;
    logic [SPAN_W-1:0] on_span;
    logic [SPAN_W-1:0] off_span;
    logic [TOD_W-1:0]  win_start;
    logic [TOD_W-1:0]  win_stop;
    logic [PCT_W-1:0]  thr_scaled;
  } pdc_cfg_t;

endpackage

/* rtl/pdc_cfg.sv */
// Configuration registers of the pump duty-cycle controller.
// Keeps the settings and registers derived spans; uses pdc_pkg.
module pdc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pdc_pkg::pdc_cfg_t                cfg
);

  pdc_pkg::run_mode_t                run_mode;
  logic [pdc_pkg::MIN_W-1:0]         on_minutes;
  logic [pdc_pkg::MIN_W-1:0]         off_minutes;
  logic [pdc_pkg::TOD_W-1:0]         window_start;
  logic [pdc_pkg::TOD_W-1:0]         window_stop;
  logic [pdc_pkg::THR_W-1:0]         light_thr;
  logic [pdc_pkg::SPAN_W-1:0]        on_span;
  logic [pdc_pkg::SPAN_W-1:0]        off_span;
  logic [pdc_pkg::PCT_W-1:0]         thr_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= pdc_pkg::RUN_NORMAL;
      on_minutes   <= pdc_pkg::RST_ON_MINUTES;
      off_minutes  <= pdc_pkg::RST_OFF_MINUTES;
      window_start <= pdc_pkg::RST_WINDOW_START;
      window_stop  <= pdc_pkg::RST_WINDOW_STOP;
      light_thr    <= pdc_pkg::RST_LIGHT_THR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdc_pkg::REG_RUN_MODE:     run_mode     <= pdc_pkg::run_mode_t'(cfg_data[1:0]);
        pdc_pkg::REG_ON_MINUTES:   on_minutes   <= cfg_data[pdc_pkg::MIN_W-1:0];
        pdc_pkg::REG_OFF_MINUTES:  off_minutes  <= cfg_data[pdc_pkg::MIN_W-1:0];
        pdc_pkg::REG_WINDOW_START: window_start <= cfg_data[pdc_pkg::TOD_W-1:0];
        pdc_pkg::REG_WINDOW_STOP:  window_stop  <= cfg_data[pdc_pkg::TOD_W-1:0];
        pdc_pkg::REG_LIGHT_THR:    light_thr    <= cfg_data[pdc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived values are registered and follow the settings in the next cycle.
  always_ff @(posedge clk) begin
    on_span    <= pdc_pkg::SPAN_W'(on_minutes) * pdc_pkg::SPAN_W'(pdc_pkg::MS_PER_MIN);
    off_span   <= pdc_pkg::SPAN_W'(off_minutes) * pdc_pkg::SPAN_W'(pdc_pkg::MS_PER_MIN);
    thr_scaled <= pdc_pkg::PCT_W'(light_thr) * pdc_pkg::PCT_W'(pdc_pkg::LIGHT_FULL);
  end

  assign cfg.run_mode   = run_mode;
  assign cfg.on_span    = on_span;
  assign cfg.off_span   = off_span;
  assign cfg.win_start  = window_start;
  assign cfg.win_stop   = window_stop;
  assign cfg.thr_scaled = thr_scaled;

endmodule

/* rtl/pdc_ctrl.sv */
// Relay decision logic and relay state of the pump duty-cycle controller.
// Decides one item per cycle while fire is high, from the registered item; uses pdc_pkg.
module pdc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          toggle,
  input  logic [pdc_pkg::NOW_W-1:0]     now_ms,
  input  logic [pdc_pkg::TOD_W-1:0]     time_of_day_ms,
  input  logic [pdc_pkg::LIGHT_W-1:0]   light_sample,
  input  pdc_pkg::pdc_cfg_t             cfg,
  output logic                          pump_on_next,
  output logic                          switched
);

  logic                          relay_on;
  logic [pdc_pkg::NOW_W-1:0]     last_switch_ms;
  logic [pdc_pkg::NOW_W-1:0]     on_limit;
  logic [pdc_pkg::NOW_W-1:0]     off_limit;
  logic [pdc_pkg::LIGHT_W-1:0]   dark_inv;
  logic [pdc_pkg::PCT_W-1:0]     light_scaled;
  logic                          step_sw;
  logic                          window_ok;
  logic                          light_ok;

  assign on_limit  = last_switch_ms + pdc_pkg::NOW_W'(cfg.on_span);
  assign off_limit = last_switch_ms + pdc_pkg::NOW_W'(cfg.off_span);

  assign step_sw = relay_on ? (on_limit < now_ms)
                            : ((off_limit < now_ms) || (last_switch_ms == '0));

  assign window_ok = (cfg.win_start <= time_of_day_ms) && (cfg.win_stop >= time_of_day_ms);

  // percent >= thr  <=>  (1023 - s) * 100 >= thr * 1023
  assign dark_inv     = pdc_pkg::LIGHT_FULL - light_sample;
  assign light_ok     = light_scaled >= cfg.thr_scaled;
  assign light_scaled = pdc_pkg::PCT_W'(dark_inv) * pdc_pkg::PCT_W'(pdc_pkg::PCT_SCALE);

  always_comb begin
    if (toggle) begin
      switched = 1'b1;
    end else begin
      unique case (cfg.run_mode)
        pdc_pkg::RUN_OFF:      switched = relay_on;
        pdc_pkg::RUN_NORMAL:   switched = step_sw;
        pdc_pkg::RUN_WINDOW:   switched = (window_ok || relay_on) && step_sw;
        pdc_pkg::RUN_DAYLIGHT: switched = (light_ok || relay_on) && step_sw;
        default:               switched = 1'b0;
      endcase
    end
  end

  // Every switch inverts the relay.
  assign pump_on_next = switched ? !relay_on : relay_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on       <= 1'b0;
      last_switch_ms <= '0;
    end else if (fire && switched) begin
      relay_on       <= pump_on_next;
      last_switch_ms <= now_ms;
    end
  end

  a_switch_stamps: assert property (@(posedge clk) disable iff (rst)
    fire && switched |=> last_switch_ms == $past(now_ms))
    else $error("last switch time not taken from the switching item");

  a_hold_no_switch: assert property (@(posedge clk) disable iff (rst)
    fire && !switched |=> relay_on == $past(relay_on) &&
                          last_switch_ms == $past(last_switch_ms))
    else $error("relay state moved without a switch");

  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    fire && toggle |=> relay_on != $past(relay_on))
    else $error("manual toggle did not invert the relay");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> relay_on == $past(relay_on))
    else $error("relay changed with no item");

endmodule

/* rtl/pump_duty_cycle_controller.sv */
// Pump duty-cycle controller.
//
// Input stream s_*: one item per accepted beat. s_tuser is the item kind
// (0 periodic check, 1 manual toggle); s_tdata carries the millisecond
// counter, the time of day and the light sample. Output stream m_*: one
// result per item, the relay state after the item and a switched flag.
// Configuration: cfg_we writes cfg_data into register cfg_addr
// (0 run mode, 1 on minutes, 2 off minutes, 3 window start, 4 window stop,
// 5 light threshold); write only while no item is in flight.
//
// An item goes into an input register, is decided from there when the result
// register can advance, and the result is registered; m_tvalid is driven by the
// result register. One item per cycle is sustained while m_tready is high: the
// relay state feeds back straight into the decision logic for the next item.
// When m_tready is low the result register holds, the input register fills,
// and s_tready drops only with both full.
// Synchronous reset turns the relay off, clears the last switch time,
// empties both registers and loads the register defaults.
module pump_duty_cycle_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] now_ms, [58:32] time_of_day_ms, [68:59] light_sample, rest zero
  input  logic [pdc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] mode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] pump_on, [1] switched, rest zero
  output logic [pdc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pdc_pkg::pdc_cfg_t               cfg;
  logic                            in_valid;
  logic                            in_mode;
  logic [pdc_pkg::NOW_W-1:0]       in_now;
  logic [pdc_pkg::TOD_W-1:0]       in_tod;
  logic [pdc_pkg::LIGHT_W-1:0]     in_light;
  logic                            out_valid;
  logic                            out_pump_on;
  logic                            out_switched;
  logic                            advance;
  logic                            fire;
  logic                            take;
  logic                            pump_on_next;
  logic                            switched;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  pdc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pdc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .toggle         (in_mode),
    .now_ms         (in_now),
    .time_of_day_ms (in_tod),
    .light_sample   (in_light),
    .cfg            (cfg),
    .pump_on_next   (pump_on_next),
    .switched       (switched)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_mode  <= s_tuser;
      in_now   <= s_tdata[31:0];
      in_tod   <= s_tdata[58:32];
      in_light <= s_tdata[68:59];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pump_on  <= pump_on_next;
      out_switched <= switched;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_switched, out_pump_on};

endmodule
